// ----- hw/rtl/rc_frame_sequence_filter_defines.svh -----
// Assertion macros used by the checker module.
`ifndef RC_FRAME_SEQUENCE_FILTER_DEFINES_SVH
`define RC_FRAME_SEQUENCE_FILTER_DEFINES_SVH

// Same-cycle implication.
`define RCFSF_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("rcfsf assertion failed");

// Next-cycle implication.
`define RCFSF_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("rcfsf assertion failed");

`endif

// ----- hw/rtl/rcfsf_pkg.sv -----
package rcfsf_pkg;

   localparam int CntBits = 32;
   localparam int NumCounters = 10;
   localparam int CntAddrBits = $clog2(NumCounters);

   localparam logic [15:0] TimeoutReset = 16'd350;
   localparam logic [15:0] HalfSeqSpace = 16'd32768;

   typedef logic [CntBits-1:0] count_type;
   typedef logic [CntAddrBits-1:0] cnt_addr_type;

   localparam cnt_addr_type CntReceived = CntAddrBits'(0);
   localparam cnt_addr_type CntValid    = CntAddrBits'(1);
   localparam cnt_addr_type CntCrc      = CntAddrBits'(2);
   localparam cnt_addr_type CntLink     = CntAddrBits'(3);
   localparam cnt_addr_type CntSource   = CntAddrBits'(4);
   localparam cnt_addr_type CntSize     = CntAddrBits'(5);
   localparam cnt_addr_type CntValue    = CntAddrBits'(6);
   localparam cnt_addr_type CntDup      = CntAddrBits'(7);
   localparam cnt_addr_type CntOrder    = CntAddrBits'(8);
   localparam cnt_addr_type CntMissed   = CntAddrBits'(9);

   localparam logic [0:0] CsrTimeout   = 1'b0;
   localparam logic [0:0] CsrLinkReady = 1'b1;

   localparam logic FuncPacket = 1'b0;
   localparam logic FuncQuery  = 1'b1;

   localparam logic [2:0] DecOk       = 3'd0;
   localparam logic [2:0] DecBadSize  = 3'd1;
   localparam logic [2:0] DecBadLink  = 3'd2;
   localparam logic [2:0] DecBadValue = 3'd3;

   localparam logic [1:0] ModeNone     = 2'd0;
   localparam logic [1:0] ModeDirect   = 2'd1;
   localparam logic [1:0] ModeSideband = 2'd2;
   localparam logic [1:0] ModeBad      = 2'd3;

   typedef enum logic [3:0] {
      VerdictAccepted = 4'd0,
      VerdictSource   = 4'd1,
      VerdictSize     = 4'd2,
      VerdictLink     = 4'd3,
      VerdictValue    = 4'd4,
      VerdictCrc      = 4'd5,
      VerdictDup      = 4'd6,
      VerdictOrder    = 4'd7,
      VerdictFailsafe = 4'd8,
      VerdictQuery    = 4'd9
   } verdict_type;

   typedef enum logic [1:0] {
      SrcZero,
      SrcMem,
      SrcReg
   } cnt_src_type;

   typedef struct packed {
      verdict_type  verdict;
      logic         store_channels;
      logic         load_safe_channels;
      logic         new_frame;
      logic         direct_active;
      logic         sideband_active;
      logic [31:0]  age_ms;
      logic [15:0]  last_sequence;
      logic         cnt_we;
      cnt_addr_type cnt_addr;
      cnt_src_type  cnt_src;
      count_type    reg_value;
   } stage_type;

endpackage

// ----- hw/rtl/rc_frame_sequence_filter.sv -----
// A request goes into s2_ff, then into the output registers that drive the response.
// Throughput: one item per cycle unless a response stalls; one counter read and write per cycle.
// A counter read that meets a write to the same entry in the same cycle is forwarded.
// Reset (synchronous, active high) clears link state, counters and entry valid bits,
// and sets timeout_ms to 350 and link_ready to 0.
module rc_frame_sequence_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [31:0] req_now_ms,
   input  logic        req_source_trusted,
   input  logic [2:0]  req_decode_result,
   input  logic [1:0]  req_packet_mode,
   input  logic [15:0] req_sequence_req,
   input  logic [3:0]  req_counter_select,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_verdict,
   output logic        rsp_store_channels,
   output logic        rsp_load_safe_channels,
   output logic        rsp_new_frame,
   output logic        rsp_direct_active,
   output logic        rsp_sideband_active,
   output logic [31:0] rsp_age_ms,
   output logic [15:0] rsp_last_sequence,
   output logic [31:0] rsp_counter_value
);

   logic [15:0] timeout_ff;
   logic        link_ready_ff;

   logic [31:0] last_time_ff, last_time_in;
   logic [15:0] last_seq_ff, last_seq_in;
   logic        seq_valid_ff, seq_valid_in;
   logic [1:0]  link_mode_ff, link_mode_in;
   logic        fresh_flag_ff, fresh_flag_in;
   rcfsf_pkg::count_type received_ff, received_in;
   rcfsf_pkg::count_type missed_ff, missed_in;

   rcfsf_pkg::count_type    cnt_mem [rcfsf_pkg::NumCounters];
   logic [rcfsf_pkg::NumCounters-1:0] entry_valid_ff;
   rcfsf_pkg::count_type    rd_data_ff;
   logic                    rd_valid_ff;
   logic                    fwd_hit_ff, fwd_hit_in;
   rcfsf_pkg::count_type    fwd_data_ff;
   rcfsf_pkg::cnt_addr_type rd_addr;

   rcfsf_pkg::stage_type s2_ff, s2_in;
   logic                 s2_valid_ff;
   logic                 s2_adv;
   rcfsf_pkg::count_type mem_value, new_count;

   logic        rsp_valid_ff;
   logic [3:0]  out_verdict_ff;
   logic        out_store_ff, out_safe_ff, out_new_ff, out_direct_ff, out_side_ff;
   logic [31:0] out_age_ff, out_count_ff, out_count_in;
   logic [15:0] out_seq_ff;

   logic        req_accept;
   logic [31:0] diff, back_diff, timeout_ext;
   logic        known, q_fresh, p_fresh;
   logic [15:0] delta;
   logic [1:0]  mode;

   assign csr_ready  = 1'b1;
   assign s2_adv     = s2_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s2_valid_ff || s2_adv;
   assign req_accept = req_valid && req_ready;

   assign timeout_ext = 32'(timeout_ff);
   assign diff        = req_now_ms - last_time_ff;
   assign back_diff   = last_time_ff - req_now_ms;
   assign known       = last_time_ff != 32'd0;
   assign q_fresh     = known && (diff[31] ? (back_diff <= timeout_ext) : (diff <= timeout_ext));
   assign p_fresh     = seq_valid_ff && known && (diff <= timeout_ext);
   assign delta       = req_sequence_req - last_seq_ff;
   assign mode        = (req_packet_mode == rcfsf_pkg::ModeBad) ? rcfsf_pkg::ModeNone
                                                                : req_packet_mode;

   always_comb begin
      last_time_in  = last_time_ff;
      last_seq_in   = last_seq_ff;
      seq_valid_in  = seq_valid_ff;
      link_mode_in  = link_mode_ff;
      fresh_flag_in = fresh_flag_ff;
      received_in   = received_ff;
      missed_in     = missed_ff;
      s2_in         = '0;
      s2_in.verdict = rcfsf_pkg::VerdictQuery;
      s2_in.cnt_src = rcfsf_pkg::SrcZero;
      if (req_func == rcfsf_pkg::FuncQuery) begin
         s2_in.new_frame       = fresh_flag_ff;
         fresh_flag_in         = 1'b0;
         s2_in.direct_active   = link_ready_ff && q_fresh &&
                                 (link_mode_ff == rcfsf_pkg::ModeDirect);
         s2_in.sideband_active = link_ready_ff && q_fresh &&
                                 (link_mode_ff == rcfsf_pkg::ModeSideband);
         s2_in.age_ms          = (!known || diff[31]) ? 32'd0 : diff;
         s2_in.last_sequence   = last_seq_ff;
         if (req_counter_select == 4'(rcfsf_pkg::CntReceived)) begin
            s2_in.cnt_src   = rcfsf_pkg::SrcReg;
            s2_in.reg_value = received_ff;
         end else if (req_counter_select == 4'(rcfsf_pkg::CntMissed)) begin
            s2_in.cnt_src   = rcfsf_pkg::SrcReg;
            s2_in.reg_value = missed_ff;
         end else if (req_counter_select < 4'(rcfsf_pkg::NumCounters)) begin
            s2_in.cnt_src  = rcfsf_pkg::SrcMem;
            s2_in.cnt_addr = rcfsf_pkg::CntAddrBits'(req_counter_select);
         end
      end else begin
         received_in  = received_ff + rcfsf_pkg::CntBits'(1);
         s2_in.cnt_we = 1'b1;
         if (!req_source_trusted) begin
            s2_in.verdict  = rcfsf_pkg::VerdictSource;
            s2_in.cnt_addr = rcfsf_pkg::CntSource;
         end else if (req_decode_result != rcfsf_pkg::DecOk) begin
            case (req_decode_result)
               rcfsf_pkg::DecBadSize: begin
                  s2_in.verdict  = rcfsf_pkg::VerdictSize;
                  s2_in.cnt_addr = rcfsf_pkg::CntSize;
               end
               rcfsf_pkg::DecBadLink: begin
                  s2_in.verdict  = rcfsf_pkg::VerdictLink;
                  s2_in.cnt_addr = rcfsf_pkg::CntLink;
               end
               rcfsf_pkg::DecBadValue: begin
                  s2_in.verdict  = rcfsf_pkg::VerdictValue;
                  s2_in.cnt_addr = rcfsf_pkg::CntValue;
               end
               default: begin
                  s2_in.verdict  = rcfsf_pkg::VerdictCrc;
                  s2_in.cnt_addr = rcfsf_pkg::CntCrc;
               end
            endcase
         end else if (p_fresh && delta == 16'd0) begin
            s2_in.verdict  = rcfsf_pkg::VerdictDup;
            s2_in.cnt_addr = rcfsf_pkg::CntDup;
         end else if (p_fresh && delta > rcfsf_pkg::HalfSeqSpace) begin
            s2_in.verdict  = rcfsf_pkg::VerdictOrder;
            s2_in.cnt_addr = rcfsf_pkg::CntOrder;
         end else begin
            if (p_fresh && delta > 16'd1) begin
               missed_in = missed_ff + rcfsf_pkg::CntBits'(delta - 16'd1);
            end
            seq_valid_in = 1'b1;
            link_mode_in = mode;
            last_time_in = req_now_ms;
            last_seq_in  = req_sequence_req;
            if (mode != rcfsf_pkg::ModeNone) begin
               fresh_flag_in        = (mode == rcfsf_pkg::ModeDirect);
               s2_in.verdict        = rcfsf_pkg::VerdictAccepted;
               s2_in.store_channels = 1'b1;
               s2_in.cnt_addr       = rcfsf_pkg::CntValid;
            end else begin
               fresh_flag_in            = 1'b0;
               s2_in.verdict            = rcfsf_pkg::VerdictFailsafe;
               s2_in.load_safe_channels = 1'b1;
               s2_in.cnt_we             = 1'b0;
            end
         end
      end
   end

   assign rd_addr    = s2_in.cnt_addr;
   assign mem_value  = fwd_hit_ff ? fwd_data_ff : (rd_valid_ff ? rd_data_ff : '0);
   assign new_count  = mem_value + rcfsf_pkg::CntBits'(1);
   assign fwd_hit_in = s2_adv && s2_ff.cnt_we && (s2_ff.cnt_addr == rd_addr);

   always_comb begin
      unique case (s2_ff.cnt_src)
         rcfsf_pkg::SrcMem: out_count_in = 32'(mem_value);
         rcfsf_pkg::SrcReg: out_count_in = 32'(s2_ff.reg_value);
         default:           out_count_in = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= rcfsf_pkg::TimeoutReset;
         link_ready_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == rcfsf_pkg::CsrTimeout) begin
            timeout_ff <= csr_wdata;
         end else begin
            link_ready_ff <= csr_wdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff  <= '0;
         last_seq_ff   <= '0;
         seq_valid_ff  <= 1'b0;
         link_mode_ff  <= rcfsf_pkg::ModeNone;
         fresh_flag_ff <= 1'b0;
         received_ff   <= '0;
         missed_ff     <= '0;
      end else if (req_accept) begin
         last_time_ff  <= last_time_in;
         last_seq_ff   <= last_seq_in;
         seq_valid_ff  <= seq_valid_in;
         link_mode_ff  <= link_mode_in;
         fresh_flag_ff <= fresh_flag_in;
         received_ff   <= received_in;
         missed_ff     <= missed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv && s2_ff.cnt_we) begin
         cnt_mem[s2_ff.cnt_addr] <= new_count;
      end
      if (req_accept) begin
         rd_data_ff  <= cnt_mem[rd_addr];
         fwd_data_ff <= new_count;
         s2_ff       <= s2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         rd_valid_ff    <= 1'b0;
         fwd_hit_ff     <= 1'b0;
         s2_valid_ff    <= 1'b0;
      end else begin
         if (s2_adv && s2_ff.cnt_we) begin
            entry_valid_ff[s2_ff.cnt_addr] <= 1'b1;
         end
         if (req_accept) begin
            rd_valid_ff <= entry_valid_ff[rd_addr];
            fwd_hit_ff  <= fwd_hit_in;
         end
         if (req_accept) begin
            s2_valid_ff <= 1'b1;
         end else if (s2_adv) begin
            s2_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         out_verdict_ff <= s2_ff.verdict;
         out_store_ff   <= s2_ff.store_channels;
         out_safe_ff    <= s2_ff.load_safe_channels;
         out_new_ff     <= s2_ff.new_frame;
         out_direct_ff  <= s2_ff.direct_active;
         out_side_ff    <= s2_ff.sideband_active;
         out_age_ff     <= s2_ff.age_ms;
         out_seq_ff     <= s2_ff.last_sequence;
         out_count_ff   <= out_count_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_verdict            = out_verdict_ff;
   assign rsp_store_channels     = out_store_ff;
   assign rsp_load_safe_channels = out_safe_ff;
   assign rsp_new_frame          = out_new_ff;
   assign rsp_direct_active      = out_direct_ff;
   assign rsp_sideband_active    = out_side_ff;
   assign rsp_age_ms             = out_age_ff;
   assign rsp_last_sequence      = out_seq_ff;
   assign rsp_counter_value      = out_count_ff;

endmodule

// ----- hw/rtl/rcfsf_checker.sv -----
`include "rc_frame_sequence_filter_defines.svh"

module rcfsf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  rsp_verdict,
   input logic        rsp_store_channels,
   input logic        rsp_load_safe_channels,
   input logic        rsp_new_frame,
   input logic [31:0] rsp_age_ms,
   input logic [31:0] rsp_counter_value
);

   logic is_query;

   assign is_query = rsp_verdict == rcfsf_pkg::VerdictQuery;

   `RCFSF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_verdict) && $stable(rsp_counter_value))
   `RCFSF_ASSERT_NOW(a_query_no_strobe, clock, reset, rsp_valid && is_query, !rsp_store_channels && !rsp_load_safe_channels)
   `RCFSF_ASSERT_NOW(a_packet_no_status, clock, reset, rsp_valid && !is_query, !rsp_new_frame && rsp_age_ms == 32'd0 && rsp_counter_value == 32'd0)
   `RCFSF_ASSERT_NOW(a_strobe_matches, clock, reset, rsp_valid, (rsp_store_channels == (rsp_verdict == rcfsf_pkg::VerdictAccepted)) && (rsp_load_safe_channels == (rsp_verdict == rcfsf_pkg::VerdictFailsafe)))

endmodule

bind rc_frame_sequence_filter rcfsf_checker u_rcfsf_checker (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_valid              (rsp_valid),
   .rsp_ready              (rsp_ready),
   .rsp_verdict            (rsp_verdict),
   .rsp_store_channels     (rsp_store_channels),
   .rsp_load_safe_channels (rsp_load_safe_channels),
   .rsp_new_frame          (rsp_new_frame),
   .rsp_age_ms             (rsp_age_ms),
   .rsp_counter_value      (rsp_counter_value)
);
